/* rtl/core/slstat_pkg.sv */
`timescale 1ns / 1ps

package slstat_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_ADD   = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NEGATIVE = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Configuration register index (word address bit 2)
  localparam logic       REG_ACTIVE_SLOTS = 1'b0;
  localparam logic [4:0] ACTIVE_RESET     = 5'd16;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [47:0] DUR_MAX    = 48'hFFFF_FFFF_FFFF;

  // Classified request, as queued between front and back
  typedef struct packed {
    opcode_e            op;
    logic [3:0]         slot;
    logic [31:0]        sec;
    logic [29:0]        nsec;
    logic signed [47:0] dur;
    status_e            status;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [47:0] interval_ns;
    logic [47:0] min_ns;
    logic [47:0] max_ns;
    logic [47:0] mean_ns;
    logic [31:0] sample_count;
  } result_t;

endpackage

/* rtl/core/slot_latency_statistics.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// request   in         push_i / full_o              opcode, slot index, time stamp, duration
// result    out        pop_i / empty_o              status, interval, min, max, mean, count
// config    in         psel/penable/pwrite, pready  active_slots at byte address 0
//
// One request is worked at a time; a two-entry queue holds further requests meanwhile.
// Rejected requests (slot out of range, negative duration) go from the queue straight to the result.
// Start, stop, add and read all wait on the 64-step divider for the mean.
// A slot with no samples skips the divider.
// Reset clears the slot tables at once through per-slot valid bits; no clearing pass.
// A finished result waits in the output register while the next request is worked.

module slot_latency_statistics import slstat_pkg::*; #(
  parameter int SLOT_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request queue side
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         slot_index_i,
  input  logic [31:0]        now_sec_i,
  input  logic [29:0]        now_nsec_i,
  input  logic signed [47:0] duration_ns_i,
  // result queue side
  output logic               empty_o,
  input  logic               pop_i,
  output logic [1:0]         status_o,
  output logic [47:0]        interval_ns_o,
  output logic [47:0]        min_ns_o,
  output logic [47:0]        max_ns_o,
  output logic [47:0]        mean_ns_o,
  output logic [31:0]        sample_count_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [4:0] active_slots_q;
  logic       cfg_write;
  logic       q_empty, q_pop;
  request_t   q_head;
  result_t    result;

  // Configuration: registers are word-addressed; writes ignore the byte offset bits, reads need them zero
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_slots_q <= ACTIVE_RESET;
    end else if (cfg_write && paddr[2] == REG_ACTIVE_SLOTS) begin
      active_slots_q <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACTIVE_SLOTS && paddr[1:0] == 2'b00) begin
      prdata = {27'd0, active_slots_q};
    end
  end

  // Front: accept and classify each request, hold it in a short queue
  slstat_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .opcode_i       (opcode_i),
    .slot_index_i   (slot_index_i),
    .now_sec_i      (now_sec_i),
    .now_nsec_i     (now_nsec_i),
    .duration_ns_i  (duration_ns_i),
    .active_slots_i (active_slots_q),
    .pop_i          (q_pop),
    .empty_o        (q_empty),
    .head_o         (q_head)
  );

  // Back: slot tables, interval arithmetic, statistics update and mean
  slstat_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (q_head),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop_i),
    .res_empty_o (empty_o),
    .result_o    (result)
  );

  assign status_o       = result.status;
  assign interval_ns_o  = result.interval_ns;
  assign min_ns_o       = result.min_ns;
  assign max_ns_o       = result.max_ns;
  assign mean_ns_o      = result.mean_ns;
  assign sample_count_o = result.sample_count;

endmodule

/* rtl/core/slstat_front.sv */
`timescale 1ns / 1ps

module slstat_front import slstat_pkg::*; #(
  parameter int SLOT_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         slot_index_i,
  input  logic [31:0]        now_sec_i,
  input  logic [29:0]        now_nsec_i,
  input  logic signed [47:0] duration_ns_i,
  input  logic [4:0]         active_slots_i,
  input  logic               pop_i,
  output logic               empty_o,
  output request_t           head_o
);

  request_t   fifo_q [2];
  request_t   req_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       in_range;
  logic       push_ok, pop_ok;

  // Classify: range check against both the register and the table depth
  assign in_range = ({1'b0, slot_index_i} < active_slots_i) &&
                    (32'(slot_index_i) < 32'(SLOT_COUNT));

  always_comb begin
    req_d.op     = opcode_e'(opcode_i);
    req_d.slot   = slot_index_i;
    req_d.sec    = now_sec_i;
    req_d.nsec   = now_nsec_i;
    req_d.dur    = duration_ns_i;
    req_d.status = ST_OK;
    if (!in_range) begin
      req_d.status = ST_RANGE;
    end else if (opcode_e'(opcode_i) == OP_ADD && duration_ns_i[47]) begin
      req_d.status = ST_NEGATIVE;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign head_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fifo_q[wr_ptr_q] <= req_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/slstat_divider.sv */
`timescale 1ns / 1ps

module slstat_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q, dvs_q;
  logic [5:0]  step_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic [33:0] diff;
  logic        borrow;

  // One quotient bit a step: restoring division
  assign trial  = {rem_q, quo_q[63]};
  assign diff   = {1'b0, trial} - {2'b00, dvs_q};
  assign borrow = diff[33];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], !borrow};
      rem_q <= borrow ? trial[31:0] : diff[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 6'd1;
        if (step_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/slstat_back.sv */
`timescale 1ns / 1ps

module slstat_back import slstat_pkg::*; #(
  parameter int SLOT_COUNT = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  request_t head_i,
  output logic     q_pop_o,
  input  logic     res_pop_i,
  output logic     res_empty_o,
  output result_t  result_o
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef struct packed {
    logic [31:0] sec;
    logic [29:0] nsec;
  } stamp_t;

  typedef struct packed {
    logic [47:0] min_ns;
    logic [47:0] max_ns;
    logic [63:0] sum;
    logic [31:0] count;
  } stats_t;

  localparam stats_t STATS_RESET = '{min_ns: DUR_MAX, max_ns: 48'd0, sum: 64'd0, count: 32'd0};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIFF  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_SUM   = 8'b0000_1000,
    S_REC   = 8'b0001_0000,
    S_DGO   = 8'b0010_0000,
    S_DWAIT = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  request_t        item_q;
  stamp_t          stamp_mem [SLOT_COUNT];
  stats_t          stats_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] stamp_vld_q, stats_vld_q;
  stamp_t          stamp_rd_q, stamp_cur;
  stats_t          stats_rd_q, stats_cur;
  logic            stamp_hit_q, stats_hit_q;
  stats_t          cur_q, rec_stats;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            take, head_ok;
  logic            borrow;
  logic [31:0]     ds_q, ds_d;
  logic [31:0]     dn_q, dn_d;
  logic [61:0]     prod_q;
  logic [63:0]     total;
  logic [47:0]     dur_q, dur_clamped;
  logic [64:0]     sum_ext;
  logic [47:0]     mean_q, mean_sat;
  logic            stamp_we, stats_we;
  logic            div_start, div_done;
  logic [63:0]     div_quot;
  result_t         res_q, res_d;
  logic            res_vld_q, res_load;

  assign head_ok = head_i.status == ST_OK;
  assign take    = (state_q == S_IDLE) && !q_empty_i;
  assign q_pop_o = take;
  assign rd_addr = AW'(head_i.slot);
  assign wr_addr = AW'(item_q.slot);

  // Entries never written read as their reset value
  assign stamp_cur = stamp_hit_q ? stamp_rd_q : '0;
  assign stats_cur = stats_hit_q ? stats_rd_q : STATS_RESET;

  // Stop: seconds and nanoseconds differences with borrow
  assign borrow = item_q.nsec < stamp_cur.nsec;
  assign ds_d   = item_q.sec - stamp_cur.sec - {31'd0, borrow};
  assign dn_d   = {2'b00, item_q.nsec} - {2'b00, stamp_cur.nsec} +
                  (borrow ? {2'b00, NS_PER_SEC} : 32'd0);

  assign total = {2'b00, prod_q} + {{32{dn_q[31]}}, dn_q};

  always_comb begin
    if (total[63]) begin
      dur_clamped = '0;
    end else if (|total[62:48]) begin
      dur_clamped = DUR_MAX;
    end else begin
      dur_clamped = total[47:0];
    end
  end

  // Record one duration: min, max, saturating sum and count
  assign sum_ext = {1'b0, cur_q.sum} + {17'd0, dur_q};

  always_comb begin
    rec_stats        = cur_q;
    rec_stats.max_ns = (dur_q >= cur_q.max_ns) ? dur_q : cur_q.max_ns;
    rec_stats.min_ns = (dur_q <= cur_q.min_ns) ? dur_q : cur_q.min_ns;
    if (cur_q.count != '1) begin
      rec_stats.count = cur_q.count + 32'd1;
      rec_stats.sum   = sum_ext[64] ? '1 : sum_ext[63:0];
    end
  end

  assign mean_sat = (|div_quot[63:48]) ? DUR_MAX : div_quot[47:0];

  assign stamp_we  = (state_q == S_DIFF) && (item_q.op == OP_START);
  assign stats_we  = state_q == S_REC;
  assign div_start = (state_q == S_DGO) && (cur_q.count != '0);
  assign res_load  = (state_q == S_OUT) && (!res_vld_q || res_pop_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = head_ok ? S_DIFF : S_OUT;
        end
      end
      S_DIFF: begin
        case (item_q.op)
          OP_STOP: state_d = S_MUL;
          OP_ADD:  state_d = S_REC;
          default: state_d = S_DGO;
        endcase
      end
      S_MUL:   state_d = S_SUM;
      S_SUM:   state_d = S_REC;
      S_REC:   state_d = S_DGO;
      S_DGO:   state_d = (cur_q.count == '0) ? S_OUT : S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d = '0;
    if (item_q.status != ST_OK) begin
      res_d.status = item_q.status;
    end else begin
      res_d.status       = (item_q.op == OP_READ && cur_q.count == '0) ? ST_EMPTY : ST_OK;
      res_d.interval_ns  = (item_q.op == OP_STOP || item_q.op == OP_ADD) ? dur_q : '0;
      res_d.min_ns       = cur_q.min_ns;
      res_d.max_ns       = cur_q.max_ns;
      res_d.mean_ns      = mean_q;
      res_d.sample_count = cur_q.count;
    end
  end

  // Slot tables: one read per request that passed classification, registered
  always_ff @(posedge clk_i) begin
    if (take && head_ok) begin
      stamp_rd_q  <= stamp_mem[rd_addr];
      stats_rd_q  <= stats_mem[rd_addr];
      stamp_hit_q <= stamp_vld_q[rd_addr];
      stats_hit_q <= stats_vld_q[rd_addr];
    end
    if (stamp_we) begin
      stamp_mem[wr_addr] <= '{sec: item_q.sec, nsec: item_q.nsec};
    end
    if (stats_we) begin
      stats_mem[wr_addr] <= rec_stats;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= head_i;
    end
    case (state_q)
      S_DIFF: begin
        cur_q <= stats_cur;
        ds_q  <= ds_d;
        dn_q  <= dn_d;
        dur_q <= item_q.dur[47:0];
      end
      S_MUL:   prod_q <= {30'd0, ds_q} * {32'd0, NS_PER_SEC};
      S_SUM:   dur_q  <= dur_clamped;
      S_REC:   cur_q  <= rec_stats;
      S_DGO:   mean_q <= '0;
      S_DWAIT: begin
        if (div_done) begin
          mean_q <= mean_sat;
        end
      end
      default: ;
    endcase
    if (res_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stamp_vld_q <= '0;
      stats_vld_q <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (stamp_we) begin
        stamp_vld_q[wr_addr] <= 1'b1;
      end
      if (stats_we) begin
        stats_vld_q[wr_addr] <= 1'b1;
      end
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_pop_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  slstat_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_q.sum),
    .divisor_i  (cur_q.count),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign res_empty_o = !res_vld_q;
  assign result_o    = res_q;

endmodule

/* rtl/core/slstat_checker.sv */
`timescale 1ns / 1ps

module slstat_checker import slstat_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty_o,
  input logic        pop_i,
  input logic [1:0]  status_o,
  input logic [47:0] interval_ns_o,
  input logic [47:0] min_ns_o,
  input logic [47:0] max_ns_o,
  input logic [47:0] mean_ns_o,
  input logic [31:0] sample_count_o
);

  // Rejected requests carry no statistics
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && (status_o == ST_RANGE || status_o == ST_NEGATIVE) |->
      interval_ns_o == '0 && min_ns_o == '0 && max_ns_o == '0 &&
      mean_ns_o == '0 && sample_count_o == '0)
    else $error("rejected result carries statistics");

  // A read of an empty slot shows the reset statistics
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && status_o == ST_EMPTY |->
      sample_count_o == '0 && mean_ns_o == '0 && max_ns_o == '0 &&
      min_ns_o == DUR_MAX && interval_ns_o == '0)
    else $error("empty-slot result malformed");

  // A recorded duration always leaves a nonzero count
  a_ok_no_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && status_o == ST_OK && sample_count_o == '0 |->
      interval_ns_o == '0 && mean_ns_o == '0)
    else $error("recorded interval without a sample");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=>
      !empty_o && $stable(status_o) && $stable(interval_ns_o) && $stable(min_ns_o) &&
      $stable(max_ns_o) && $stable(mean_ns_o) && $stable(sample_count_o))
    else $error("waiting result changed");

endmodule

bind slot_latency_statistics slstat_checker u_slstat_checker (.*);

/* tb/sv/slot_latency_statistics_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the slot latency statistics block. Requests go in
// through the push/full queue, results come back through the empty/pop queue,
// and a private copy of the slot tables predicts every result in request order.

module slot_latency_statistics_tb;
  import slstat_pkg::*;

  localparam int          SLOTS         = 16;
  localparam int          SETTLE_CYCLES = 120;     // longer than the slowest request takes
  localparam int          CYCLE_LIMIT   = 2000000;
  localparam logic [47:0] SAT48         = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] SAT64         = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;
  localparam longint      NS_IN_SEC     = 64'sd1000000000;
  localparam logic [2:0]  ACTIVE_ADDR   = {REG_ACTIVE_SLOTS, 2'b00};

  // One request as the bench sees it
  typedef struct {
    opcode_e     op;
    logic [3:0]  slot;
    logic [31:0] sec;
    logic [29:0] nsec;
    logic [47:0] dur;
  } timing_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push_i = 1'b0;
  logic               full_o;
  logic [1:0]         opcode_i = '0;
  logic [3:0]         slot_index_i = '0;
  logic [31:0]        now_sec_i = '0;
  logic [29:0]        now_nsec_i = '0;
  logic signed [47:0] duration_ns_i = '0;
  logic               empty_o;
  logic               pop_i = 1'b0;
  logic [1:0]         status_o;
  logic [47:0]        interval_ns_o;
  logic [47:0]        min_ns_o;
  logic [47:0]        max_ns_o;
  logic [47:0]        mean_ns_o;
  logic [31:0]        sample_count_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  slot_latency_statistics #(.SLOT_COUNT(SLOTS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .opcode_i      (opcode_i),
    .slot_index_i  (slot_index_i),
    .now_sec_i     (now_sec_i),
    .now_nsec_i    (now_nsec_i),
    .duration_ns_i (duration_ns_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .status_o      (status_o),
    .interval_ns_o (interval_ns_o),
    .min_ns_o      (min_ns_o),
    .max_ns_o      (max_ns_o),
    .mean_ns_o     (mean_ns_o),
    .sample_count_o(sample_count_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow of the slot tables and of the active_slots register
  logic [31:0] stamp_sec    [SLOTS];
  logic [29:0] stamp_nsec   [SLOTS];
  logic [47:0] min_seen     [SLOTS];
  logic [47:0] max_seen     [SLOTS];
  logic [63:0] total_ns     [SLOTS];
  logic [31:0] sample_tally [SLOTS];
  logic [4:0]  active_slots_shadow;

  timing_req_t queued_requests[$];   // built by the stimulus, drained by the driver
  result_t     awaited_results[$];   // predicted results, oldest first
  timing_req_t req_on_bus;

  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  int unsigned calm_left     = 0;
  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  int unsigned phase_slots [7] = '{16, 5, 1, 31, 12, 16, 2};

  // Free-running clock, 10 ns period
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block locks up
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL slot_latency_statistics");
      $finish;
    end
  end

  // Pause length for either side: mostly none or short, now and then long, and every
  // so often a calm stretch with no pauses at all.
  function automatic int unsigned idle_span();
    int unsigned pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 199);
    if (pick == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 100) return 0;
    if (pick < 170) return $urandom_range(1, 3);
    if (pick < 194) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // Apply one accepted request to the shadow tables and return the result it must give.
  function automatic result_t slot_statistics_after(timing_req_t r);
    result_t     res;
    int unsigned limit;
    logic [31:0] dsec;
    logic [47:0] dur;
    logic [63:0] mean64;
    longint      dns;
    longint      total;
    bit          record;
    res    = '0;
    record = 1'b0;
    dur    = '0;
    limit  = (active_slots_shadow < SLOTS) ? active_slots_shadow : SLOTS;
    if (r.slot >= limit) begin
      res.status = ST_RANGE;
      return res;
    end
    case (r.op)
      OP_START: begin
        stamp_sec[r.slot]  = r.sec;
        stamp_nsec[r.slot] = r.nsec;
      end
      OP_STOP: begin
        // Borrow a second when the nanoseconds went backwards; seconds wrap mod 2^32
        dsec = r.sec - stamp_sec[r.slot];
        if (r.nsec < stamp_nsec[r.slot]) begin
          dsec = dsec - 32'd1;
          dns  = NS_IN_SEC - (longint'(stamp_nsec[r.slot]) - longint'(r.nsec));
        end else begin
          dns = longint'(r.nsec) - longint'(stamp_nsec[r.slot]);
        end
        total = longint'({32'd0, dsec}) * NS_IN_SEC + dns;
        if (total < 0) total = 0;
        if (total > longint'({16'd0, SAT48})) dur = SAT48;
        else dur = total[47:0];
        record = 1'b1;
      end
      OP_ADD: begin
        if (r.dur[47]) begin
          res.status = ST_NEGATIVE;
          return res;
        end
        dur    = r.dur;
        record = 1'b1;
      end
      default: ;
    endcase
    if (record) begin
      if (dur >= max_seen[r.slot]) max_seen[r.slot] = dur;
      if (dur <= min_seen[r.slot]) min_seen[r.slot] = dur;
      if (sample_tally[r.slot] != SAT32) begin
        sample_tally[r.slot] = sample_tally[r.slot] + 32'd1;
        if (total_ns[r.slot] > SAT64 - {16'd0, dur}) total_ns[r.slot] = SAT64;
        else total_ns[r.slot] = total_ns[r.slot] + {16'd0, dur};
      end
      res.interval_ns = dur;
    end
    mean64 = '0;
    if (sample_tally[r.slot] != 0) mean64 = total_ns[r.slot] / {32'd0, sample_tally[r.slot]};
    res.min_ns       = min_seen[r.slot];
    res.max_ns       = max_seen[r.slot];
    res.mean_ns      = (mean64 > {16'd0, SAT48}) ? SAT48 : mean64[47:0];
    res.sample_count = sample_tally[r.slot];
    if (r.op == OP_READ && sample_tally[r.slot] == 0) res.status = ST_EMPTY;
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("ERROR result %0d %s: got %0h want %0h", results_seen, what, got, want);
  endtask

  // Request driver: hold a request until it is taken, then pause at random before the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) awaited_results.push_back(slot_statistics_after(req_on_bus));
      if (!push_i || !full_o) begin
        if (send_gap > 0) begin
          send_gap--;
          push_i <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          req_on_bus = queued_requests.pop_front();
          opcode_i      <= req_on_bus.op;
          slot_index_i  <= req_on_bus.slot;
          now_sec_i     <= req_on_bus.sec;
          now_nsec_i    <= req_on_bus.nsec;
          duration_ns_i <= req_on_bus.dur;
          push_i        <= 1'b1;
          send_gap = idle_span();
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken result with the oldest prediction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("result with none outstanding", {62'd0, status_o}, '0);
        end else begin
          result_t want;
          want = awaited_results.pop_front();
          if (status_o !== want.status)
            note_mismatch("status", {62'd0, status_o}, {62'd0, want.status});
          if (interval_ns_o !== want.interval_ns)
            note_mismatch("interval_ns", {16'd0, interval_ns_o}, {16'd0, want.interval_ns});
          if (min_ns_o !== want.min_ns)
            note_mismatch("min_ns", {16'd0, min_ns_o}, {16'd0, want.min_ns});
          if (max_ns_o !== want.max_ns)
            note_mismatch("max_ns", {16'd0, max_ns_o}, {16'd0, want.max_ns});
          if (mean_ns_o !== want.mean_ns)
            note_mismatch("mean_ns", {16'd0, mean_ns_o}, {16'd0, want.mean_ns});
          if (sample_count_o !== want.sample_count)
            note_mismatch("sample_count", {32'd0, sample_count_o}, {32'd0, want.sample_count});
        end
        results_seen++;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
        if (pop_i && !empty_o) recv_gap = idle_span();
      end
    end
  end

  task automatic enqueue(opcode_e op, logic [3:0] slot, logic [31:0] sec, logic [29:0] nsec,
                         logic [47:0] dur);
    timing_req_t r;
    r.op   = op;
    r.slot = slot;
    r.sec  = sec;
    r.nsec = nsec;
    r.dur  = dur;
    queued_requests.push_back(r);
  endtask

  // Wait until every request has gone in and every result has come out, then let the
  // block settle before touching the register.
  task automatic settle_idle();
    while (!(queued_requests.size() == 0 && !push_i && awaited_results.size() == 0))
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write active_slots over the APB port, then read it back
  task automatic set_active_slots(logic [4:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACTIVE_ADDR;
    pwdata  <= {27'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    active_slots_shadow = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {27'd0, value})
      note_mismatch("active_slots read back", {32'd0, prdata}, {59'd0, value});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [3:0] pick_slot();
    int unsigned limit;
    limit = (active_slots_shadow < SLOTS) ? active_slots_shadow : SLOTS;
    if (limit == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, limit - 1));
  endfunction

  function automatic logic [47:0] any_dur();
    return 48'({$urandom, $urandom});
  endfunction

  // Mostly well-formed start/stop pairs, adds and reads on live slots; the rest is noise
  task automatic random_traffic(int unsigned amount);
    int unsigned made;
    int unsigned kind;
    int unsigned stops;
    logic [3:0]  slot;
    logic [31:0] sec0;
    logic [31:0] sec1;
    logic [29:0] nsec1;
    logic [47:0] dur;
    made = 0;
    while (made < amount) begin
      kind = $urandom_range(0, 99);
      slot = pick_slot();
      if (kind < 40) begin
        sec0 = $urandom;
        enqueue(OP_START, slot, sec0, 30'($urandom_range(0, 999999999)), any_dur());
        made++;
        stops = ($urandom_range(0, 3) == 0) ? 2 : 1;
        repeat (stops) begin
          case ($urandom_range(0, 9))
            0:       sec1 = $urandom;                              // wrap or clamp
            1, 2:    sec1 = sec0 + $urandom_range(0, 400000);     // around the clamp
            default: sec1 = sec0 + $urandom_range(0, 2);
          endcase
          if ($urandom_range(0, 19) == 0) nsec1 = 30'($urandom_range(1000000000, 30'h3FFF_FFFF));
          else nsec1 = 30'($urandom_range(0, 999999999));
          enqueue(OP_STOP, slot, sec1, nsec1, any_dur());
          made++;
        end
      end else if (kind < 60) begin
        case ($urandom_range(0, 9))
          0, 1:    dur = any_dur();                   // half of these are negative
          2:       dur = {1'b0, 47'({$urandom, $urandom})};
          default: dur = 48'($urandom_range(0, 1 << 20));
        endcase
        enqueue(OP_ADD, slot, $urandom, 30'($urandom), dur);
        made++;
      end else if (kind < 75) begin
        enqueue(OP_READ, slot, $urandom, 30'($urandom), any_dur());
        made++;
      end else begin
        enqueue(opcode_e'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom,
                30'($urandom), any_dur());
        made++;
      end
    end
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      stamp_sec[s]    = '0;
      stamp_nsec[s]   = '0;
      min_seen[s]     = SAT48;
      max_seen[s]     = '0;
      total_ns[s]     = '0;
      sample_tally[s] = '0;
    end
    active_slots_shadow = ACTIVE_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: empty slot read, stop with no start, borrow across a second,
    // add extremes and negative rejects, seconds wrap, long-interval clamp, a total
    // below zero, equal durations, and range checks under unusual active_slots values.
    enqueue(OP_READ,  4'd0,  '0,            '0,            '0);
    enqueue(OP_STOP,  4'd1,  32'd3,         30'd5,         '0);
    enqueue(OP_START, 4'd2,  32'd100,       30'd999999999, '0);
    enqueue(OP_STOP,  4'd2,  32'd101,       30'd0,         '0);
    enqueue(OP_ADD,   4'd3,  '0,            '0,            48'd0);
    enqueue(OP_ADD,   4'd3,  '0,            '0,            48'h7FFF_FFFF_FFFF);
    enqueue(OP_ADD,   4'd3,  '0,            '0,            48'hFFFF_FFFF_FFFF);
    enqueue(OP_ADD,   4'd3,  '0,            '0,            48'h8000_0000_0000);
    enqueue(OP_READ,  4'd3,  32'hFFFF_FFFF, 30'h3FFF_FFFF, 48'hFFFF_FFFF_FFFF);
    enqueue(OP_START, 4'd4,  32'hFFFF_FFFF, 30'd0,         '0);
    enqueue(OP_STOP,  4'd4,  32'd0,         30'd5,         '0);
    enqueue(OP_START, 4'd5,  32'd0,         30'd0,         '0);
    enqueue(OP_STOP,  4'd5,  32'hFFFF_FFFF, 30'h3FFF_FFFF, '0);
    enqueue(OP_START, 4'd6,  32'd10,        30'h3FFF_FFFF, '0);
    enqueue(OP_STOP,  4'd6,  32'd11,        30'd0,         '0);
    enqueue(OP_STOP,  4'd6,  32'd10,        30'h3FFF_FFFF, '0);
    enqueue(OP_START, 4'd15, 32'd7,         30'd999999999, '0);
    enqueue(OP_READ,  4'd15, '0,            '0,            '0);
    enqueue(OP_ADD,   4'd15, '0,            '0,            48'd1234);
    settle_idle();
    set_active_slots(5'd1);
    enqueue(OP_READ,  4'd0,  '0,            '0,            '0);
    enqueue(OP_ADD,   4'd1,  '0,            '0,            48'd5);
    settle_idle();
    set_active_slots(5'd0);
    enqueue(OP_READ,  4'd0,  '0,            '0,            '0);
    enqueue(OP_START, 4'd15, 32'd1,         30'd1,         '0);
    settle_idle();
    set_active_slots(5'd31);
    enqueue(OP_READ,  4'd15, '0,            '0,            '0);
    settle_idle();

    // Random part, one phase per active_slots setting
    foreach (phase_slots[p]) begin
      set_active_slots(5'(phase_slots[p]));
      random_traffic(190);
      settle_idle();
    end

    if (awaited_results.size() != 0)
      note_mismatch("results never delivered", 64'(awaited_results.size()), '0);
    if (error_count == 0) begin
      $display("PASS slot_latency_statistics");
    end else begin
      $display("FAIL slot_latency_statistics");
    end
    $finish;
  end

endmodule
